// ===== rtl/ntt_pkg.sv =====
// shared constants, types and constant arithmetic for the ntt block
package ntt_pkg;

  localparam logic [30:0] P = 31'd2013265921;
  localparam logic [30:0] G = 31'd31;
  localparam int unsigned TWO_ADICITY = 27;
  localparam logic [31:0] MU = 32'((64'd1 << 62) / 64'(P));

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_RUN  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic {
    CFG_INVERSE = 1'b0,
    CFG_LOG2LEN = 1'b1
  } cfg_idx_e;

  typedef logic [30:0] resid_t;

  function automatic resid_t pow_mod(logic [63:0] base, logic [63:0] ex);
    logic [63:0] acc;
    logic [63:0] b;
    logic [63:0] e;
    acc = 64'd1;
    b = base % 64'(P);
    e = ex;
    for (int k = 0; k < 64; k++) begin
      if (e[0]) acc = (acc * b) % 64'(P);
      b = (b * b) % 64'(P);
      e = e >> 1;
    end
    return resid_t'(acc);
  endfunction

endpackage

// ===== rtl/ntt_if.sv =====
// valid/ready channel interfaces for items and results
interface ntt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [9:0]  index;
  logic [30:0] value;
  modport source (output valid, func, index, value, input ready);
  modport sink (input valid, func, index, value, output ready);
endinterface

interface ntt_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/ntt_radix2_transform.sv =====
// ntt top level: coefficient store, sequencer and item/result channels
// A load and a read each take one beat; a read result passes through the
// store read register and the output register, and the channel takes no new
// beat while the read is pending. A run holds off input for a bit-reversal
// scan over entries 1 to N-1 that swaps each pair through the single store
// read port, then for (N/2)log2(N) butterflies, each through the single store
// read port and the four-stage modular multiplier that also advances the
// twiddle; an inverse run then scales every entry by the inverse of the
// length. N = 2^log2_len, capped at MAX_LEN.
module ntt_radix2_transform import ntt_pkg::*; #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ntt_in_if.sink     in_i,
  ntt_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LOG_MAX = AW;
  localparam int unsigned SW = $clog2(LOG_MAX + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BR, S_BR1, S_BR2, S_BR3,
    S_BF0, S_BF1, S_BF2, S_BF3, S_BFV, S_BFW, S_BFX,
    S_SC0, S_SC1, S_SC2
  } state_e;

  state_e        state_q;
  logic          inv_q;
  logic [3:0]    lg_q;
  logic          rd_pend_q;
  logic          out_valid_q;
  resid_t        out_q;
  logic [AW-1:0] i_q;
  logic [AW-1:0] j_q;
  logic [SW-1:0] s_q;
  resid_t        u_q;
  resid_t        v_q;
  resid_t        w_q;
  resid_t        tmp_q;

  resid_t fwd_tab [LOG_MAX+1];
  resid_t inv_tab [LOG_MAX+1];
  resid_t ninv_tab [LOG_MAX+1];

  for (genvar g = 0; g <= LOG_MAX; g++) begin : g_tab
    assign fwd_tab[g]  = pow_mod(64'(G), 64'(P - 31'd1) >> g);
    assign inv_tab[g]  = pow_mod(64'(G), 64'(P - 31'd1) - (64'(P - 31'd1) >> g));
    assign ninv_tab[g] = pow_mod(64'd2, 64'(P - 31'd1) - 64'(g));
  end

  logic [3:0]    lg;
  logic [SW-1:0] lg_eff;
  logic [AW:0]   n_full;
  logic [AW-1:0] last_i;
  logic [AW-1:0] last_j;
  logic [AW-1:0] rev_full;
  logic [AW-1:0] rev_i;
  logic [AW-1:0] half;
  logic [AW-1:0] k_lo;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] in_addr;
  resid_t        step;
  resid_t        load_val;
  logic [31:0]   sum;
  resid_t        sum_r;
  resid_t        diff_r;
  logic          in_fire;
  logic          swap;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  resid_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  resid_t        ram_rdata;
  logic          m_in_valid;
  resid_t        m_a;
  resid_t        m_b;
  logic          m_valid;
  resid_t        m_r;

  assign lg     = (lg_q == 4'd0) ? 4'd1 : lg_q;
  assign lg_eff = (int'(lg) > int'(LOG_MAX)) ? SW'(LOG_MAX) : SW'(lg);
  assign n_full = (AW+1)'(1) << lg_eff;
  assign last_i = AW'(n_full - (AW+1)'(1));
  assign last_j = AW'((n_full >> 1) - (AW+1)'(1));

  always_comb begin
    for (int b = 0; b < AW; b++) rev_full[b] = i_q[AW-1-b];
  end
  assign rev_i = rev_full >> (AW - int'(lg_eff));
  assign swap  = i_q < rev_i;

  assign half   = AW'(1) << (s_q - SW'(1));
  assign k_lo   = j_q & (half - AW'(1));
  assign addr_a = ((j_q & ~(half - AW'(1))) << 1) | k_lo;
  assign addr_b = addr_a | half;
  assign step   = inv_q ? inv_tab[s_q] : fwd_tab[s_q];

  assign in_addr  = AW'(in_i.index);
  assign load_val = (in_i.value >= P) ? in_i.value - P : in_i.value;
  assign sum      = 32'(u_q) + 32'(v_q);
  assign sum_r    = (sum >= 32'(P)) ? 31'(sum - 32'(P)) : sum[30:0];
  assign diff_r   = (u_q >= v_q) ? u_q - v_q : 31'(32'(u_q) + 32'(P) - 32'(v_q));

  assign in_i.ready = (state_q == S_IDLE) && !rd_pend_q && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = i_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = i_q;
    m_in_valid = 1'b0;
    m_a        = w_q;
    m_b        = ram_rdata;
    unique case (state_q)
      S_IDLE: begin
        ram_waddr = in_addr;
        ram_wdata = load_val;
        ram_raddr = in_addr;
        ram_we    = in_fire && (in_i.func == FUNC_LOAD);
        ram_re    = in_fire && (in_i.func == FUNC_READ);
      end
      S_BR:  ram_re = swap;
      S_BR1: begin
        ram_re    = 1'b1;
        ram_raddr = rev_i;
      end
      S_BR2: ram_we = 1'b1;
      S_BR3: begin
        ram_we    = 1'b1;
        ram_waddr = rev_i;
        ram_wdata = tmp_q;
      end
      S_BF0: begin
        ram_re    = 1'b1;
        ram_raddr = addr_a;
      end
      S_BF1: begin
        ram_re    = 1'b1;
        ram_raddr = addr_b;
      end
      S_BF2: m_in_valid = 1'b1;
      S_BF3: begin
        m_in_valid = 1'b1;
        m_b        = step;
      end
      S_BFV: ;
      S_BFW: begin
        ram_we    = 1'b1;
        ram_waddr = addr_a;
        ram_wdata = sum_r;
      end
      S_BFX: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = diff_r;
      end
      S_SC0: ram_re = 1'b1;
      S_SC1: begin
        m_in_valid = 1'b1;
        m_a        = ram_rdata;
        m_b        = ninv_tab[lg_eff];
      end
      S_SC2: begin
        ram_we    = m_valid;
        ram_wdata = m_r;
      end
      default: ;
    endcase
  end

  ntt_ram #(.WIDTH(31), .DEPTH(MAX_LEN)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ntt_modmul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_in_valid),
    .a_i     (m_a),
    .b_i     (m_b),
    .valid_o (m_valid),
    .r_o     (m_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inv_q       <= 1'b0;
      lg_q        <= 4'd10;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      s_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_INVERSE: inv_q <= cfg_data_i[0];
          CFG_LOG2LEN: lg_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      rd_pend_q <= 1'b0;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
        out_q       <= ram_rdata;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire && in_i.func == FUNC_READ) rd_pend_q <= 1'b1;
          if (in_fire && in_i.func == FUNC_RUN) begin
            i_q     <= AW'(1);
            state_q <= S_BR;
          end
        end
        S_BR, S_BR3: begin
          if (state_q == S_BR && swap) begin
            state_q <= S_BR1;
          end else if (i_q == last_i) begin
            s_q     <= SW'(1);
            j_q     <= '0;
            state_q <= S_BF0;
          end else begin
            i_q     <= i_q + AW'(1);
            state_q <= S_BR;
          end
        end
        S_BR1: begin
          tmp_q   <= ram_rdata;
          state_q <= S_BR2;
        end
        S_BR2: state_q <= S_BR3;
        S_BF0: begin
          if (k_lo == '0) w_q <= 31'd1;
          state_q <= S_BF1;
        end
        S_BF1: begin
          u_q     <= ram_rdata;
          state_q <= S_BF2;
        end
        S_BF2: state_q <= S_BF3;
        S_BF3: state_q <= S_BFV;
        S_BFV: begin
          if (m_valid) begin
            v_q     <= m_r;
            state_q <= S_BFW;
          end
        end
        S_BFW: begin
          w_q     <= m_r;
          state_q <= S_BFX;
        end
        S_BFX: begin
          if (j_q != last_j) begin
            j_q     <= j_q + AW'(1);
            state_q <= S_BF0;
          end else if (s_q != lg_eff) begin
            s_q     <= s_q + SW'(1);
            j_q     <= '0;
            state_q <= S_BF0;
          end else if (inv_q) begin
            i_q     <= '0;
            state_q <= S_SC0;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SC0: state_q <= S_SC1;
        S_SC1: state_q <= S_SC2;
        S_SC2: begin
          if (m_valid) begin
            if (i_q == last_i) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + AW'(1);
              state_q <= S_SC0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_pend_q |=> out_valid_q)
    else $error("read beat did not produce a result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == S_IDLE && !rd_pend_q))
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BFV && m_valid) |=> m_valid)
    else $error("twiddle product missing after butterfly product");

endmodule

// ===== rtl/ntt_ram.sv =====
// generic simple dual port ram with registered read
module ntt_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ntt_modmul.sv =====
// four stage barrett modular multiplier
module ntt_modmul import ntt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  resid_t a_i,
  input  resid_t b_i,
  output logic   valid_o,
  output resid_t r_o
);

  logic [3:0]  vld_q;
  logic [61:0] prod1_q;
  logic [32:0] low2_q;
  logic [31:0] quo2_q;
  logic [32:0] rem3_q;
  resid_t      r4_q;
  logic [63:0] qprod;
  logic [62:0] qp;
  logic [32:0] rem_d;
  logic [32:0] rem_m1;
  logic [32:0] rem_m2;

  assign qprod = 64'(prod1_q[61:30]) * 64'(MU);
  assign qp    = 63'(quo2_q) * 63'(P);
  assign rem_d = low2_q - qp[32:0];
  assign rem_m1 = rem3_q - 33'(P);
  assign rem_m2 = rem3_q - 33'({P, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= 62'(a_i) * 62'(b_i);
    low2_q  <= prod1_q[32:0];
    quo2_q  <= qprod[63:32];
    rem3_q  <= rem_d;
    if (rem3_q < 33'(P)) begin
      r4_q <= rem3_q[30:0];
    end else if (rem_m1 < 33'(P)) begin
      r4_q <= rem_m1[30:0];
    end else begin
      r4_q <= rem_m2[30:0];
    end
  end

  assign valid_o = vld_q[3];
  assign r_o     = r4_q;

endmodule
